// ===== design/hce_pkg.sv =====
// Shared types, constants and the step table of the height estimator.
// Used by the controller, the datapath, the multiply unit and the top level.
package hce_pkg;

  typedef logic signed [47:0] len_t;
  typedef logic signed [49:0] wide_t;

  localparam wide_t MAX48 = (50'sd1 <<< 47) - 50'sd1;
  localparam wide_t MIN48 = -(50'sd1 <<< 47);

  localparam logic [24:0] GAIN_LPF = 25'd6554;
  localparam logic [24:0] GAIN_FEEDBACK = 25'd1311;
  localparam logic [16:0] GAIN_RESET = 17'd62259;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [2:0] CFG_BARO_WEIGHT = 3'd0;
  localparam logic [2:0] CFG_ACC_DEADBAND = 3'd1;
  localparam logic [2:0] CFG_VEL_CLAMP = 3'd2;
  localparam logic [2:0] CFG_QUALITY_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_RANGE_MAX = 3'd4;

  typedef enum logic [1:0] {S16, S24, S25} shift_t;

  typedef enum logic [3:0] {
    A_RNG_DIFF, A_RNG, A_REL, A_FUS_DIFF, A_ACC_DIFF, A_HERR, A_T1, A_VEL, A_ACCZ, A_T3
  } asel_t;

  typedef enum logic [2:0] {B_LPF, B_QUAL, B_QINV, B_FB, B_W, B_DT} bsel_t;

  typedef enum logic [3:0] {
    OP_PREP, OP_RNG, OP_QUAL, OP_T1, OP_FUSE, OP_FLP, OP_RESET, OP_ASM,
    OP_ACCZ, OP_T2, OP_T3, OP_POSV, OP_HERR, OP_EW, OP_VFIN
  } alu_t;

  typedef struct packed {
    logic   is_mul;
    asel_t  a;
    bsel_t  b;
    shift_t s;
    alu_t   op;
  } uop_t;

  typedef struct packed {
    logic   load_in;
    logic   mul_lo;
    logic   mul_hi;
    logic   mul_fin;
    logic   alu_en;
    asel_t  a;
    bsel_t  b;
    shift_t s;
    alu_t   op;
    logic   load_out;
  } cmd_t;

  localparam logic [4:0] PROG_LAST = 5'd18;

  function automatic uop_t prog(input logic [4:0] idx);
    uop_t u;
    u = '{1'b0, A_T1, B_W, S16, OP_PREP};
    case (idx)
      5'd0:  u = '{1'b0, A_T1, B_W, S16, OP_PREP};
      5'd1:  u = '{1'b1, A_RNG_DIFF, B_LPF, S16, OP_RNG};
      5'd2:  u = '{1'b0, A_T1, B_W, S16, OP_QUAL};
      5'd3:  u = '{1'b1, A_RNG, B_QUAL, S16, OP_T1};
      5'd4:  u = '{1'b1, A_REL, B_QINV, S16, OP_FUSE};
      5'd5:  u = '{1'b1, A_FUS_DIFF, B_LPF, S16, OP_FLP};
      5'd6:  u = '{1'b0, A_T1, B_W, S16, OP_RESET};
      5'd7:  u = '{1'b1, A_ACC_DIFF, B_LPF, S16, OP_ASM};
      5'd8:  u = '{1'b1, A_HERR, B_FB, S16, OP_T1};
      5'd9:  u = '{1'b1, A_T1, B_W, S16, OP_T1};
      5'd10: u = '{1'b1, A_T1, B_W, S16, OP_T1};
      5'd11: u = '{1'b1, A_T1, B_DT, S24, OP_ACCZ};
      5'd12: u = '{1'b1, A_VEL, B_DT, S24, OP_T2};
      5'd13: u = '{1'b1, A_ACCZ, B_DT, S24, OP_T3};
      5'd14: u = '{1'b1, A_T3, B_DT, S25, OP_POSV};
      5'd15: u = '{1'b0, A_T1, B_W, S16, OP_HERR};
      5'd16: u = '{1'b1, A_HERR, B_W, S16, OP_T1};
      5'd17: u = '{1'b1, A_T1, B_DT, S24, OP_EW};
      5'd18: u = '{1'b1, A_T1, B_W, S16, OP_VFIN};
      default: u = '{1'b0, A_T1, B_W, S16, OP_PREP};
    endcase
    return u;
  endfunction

  function automatic wide_t ext50(input len_t x);
    return {{2{x[47]}}, x};
  endfunction

  function automatic len_t sat48(input wide_t v);
    len_t r;
    if (v > MAX48) r = MAX48[47:0];
    else if (v < MIN48) r = MIN48[47:0];
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ===== design/hce_mulq.sv =====
// Shared rounding multiplier: signed length times unsigned weight, shifted and saturated.
// Three steps per product; depends on hce_pkg.
module hce_mulq import hce_pkg::*; (
  input  logic        clk,
  input  logic        mul_lo,
  input  logic        mul_hi,
  input  logic        mul_fin,
  input  len_t        a,
  input  logic [24:0] b,
  input  shift_t      s,
  output len_t        mres
);

  logic        neg;
  logic [47:0] m;
  logic [48:0] plo;
  logic [48:0] phi;
  logic [75:0] total;
  logic [75:0] rnd;
  logic [75:0] shifted;
  logic [48:0] mag;

  assign neg = a[47];
  assign m = neg ? (~a + 48'd1) : a;

  always_comb begin
    case (s)
      S16: rnd = 76'd1 << 15;
      S24: rnd = 76'd1 << 23;
      S25: rnd = 76'd1 << 24;
      default: rnd = 76'd1 << 15;
    endcase
    total = ({27'd0, phi} << 24) + {27'd0, plo} + rnd;
    case (s)
      S16: shifted = total >> 16;
      S24: shifted = total >> 24;
      S25: shifted = total >> 25;
      default: shifted = total >> 16;
    endcase
    // The magnitude is capped at 2^48 before the sign goes back on.
    if (shifted > (76'd1 << 48)) mag = 49'd1 << 48;
    else mag = shifted[48:0];
  end

  always_ff @(posedge clk) begin
    if (mul_lo) plo <= 49'(m[23:0]) * 49'(b);
    if (mul_hi) phi <= 49'(m[47:24]) * 49'(b);
    if (mul_fin) begin
      if (neg) begin
        if (mag >= (49'd1 << 47)) mres <= MIN48[47:0];
        else mres <= -len_t'(mag[47:0]);
      end else begin
        if (mag > {2'b00, 47'h7FFF_FFFF_FFFF}) mres <= MAX48[47:0];
        else mres <= len_t'(mag[47:0]);
      end
    end
  end

endmodule

// ===== design/hce_ctrl.sv =====
// Step sequencer of the height estimator: walks the step table and issues commands.
// Depends on hce_pkg.
module hce_ctrl import hce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  typedef enum logic [1:0] {PH_LO, PH_HI, PH_FIN, PH_ALU} phase_t;

  state_t     state;
  phase_t     phase;
  logic [4:0] idx;
  uop_t       u;
  uop_t       u_next;
  uop_t       u_first;

  assign u = prog(idx);
  assign u_next = prog(idx + 5'd1);
  assign u_first = prog(5'd0);
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd.load_in = (state == IDLE) && in_valid;
    cmd.mul_lo = (state == RUN) && (phase == PH_LO);
    cmd.mul_hi = (state == RUN) && (phase == PH_HI);
    cmd.mul_fin = (state == RUN) && (phase == PH_FIN);
    cmd.alu_en = (state == RUN) && (phase == PH_ALU);
    cmd.a = u.a;
    cmd.b = u.b;
    cmd.s = u.s;
    cmd.op = u.op;
    cmd.load_out = (state == FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      phase <= PH_ALU;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= RUN;
            idx <= '0;
            phase <= u_first.is_mul ? PH_LO : PH_ALU;
          end
        end
        RUN: begin
          case (phase)
            PH_LO: phase <= PH_HI;
            PH_HI: phase <= PH_FIN;
            PH_FIN: phase <= PH_ALU;
            default: begin
              if (idx == PROG_LAST) begin
                state <= FINISH;
              end else begin
                idx <= idx + 5'd1;
                phase <= u_next.is_mul ? PH_LO : PH_ALU;
              end
            end
          endcase
        end
        FINISH: begin
          if (!out_valid || out_ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/hce_datapath.sv =====
// Datapath of the height estimator: configuration, filter state, temporaries and output.
// Depends on hce_pkg and hce_mulq.
module hce_datapath import hce_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  len_t        baro_alt,
  input  logic [31:0] range_dist,
  input  logic [16:0] range_quality,
  input  logic        range_present,
  input  len_t        accel_z,
  input  logic [23:0] step_time,
  input  logic        hold_or_land,
  input  logic        height_reset_req,
  input  logic        full_reset_req,
  output len_t        accel_out,
  output len_t        position_est,
  output len_t        velocity_est,
  output len_t        fused_smooth
);

  localparam len_t ACC_LIM = 48'sd1000 <<< FRAC_BITS;

  logic [16:0] baro_weight, quality_threshold;
  logic [25:0] acc_deadband, vel_clamp;
  logic [15:0] range_max;

  len_t        baro, acc;
  logic [31:0] rdist;
  logic [16:0] qual;
  logic        present, hold;
  logic [23:0] dt;

  len_t range_smooth, accel_smooth, fused_lowpass, takeoff_ref;
  len_t pos_state, vel_state, height_error;
  logic height_reset_pending, full_reset_pending;

  len_t        rel, fused, dead, accz, accout, t1, t2, t3;
  logic [16:0] w;

  len_t        a_op, mres, dist_len, db, vlim, as_new, v_new;
  logic [24:0] b_op;
  logic        take_range;
  len_t        ref_take, pos_take;

  hce_mulq u_mulq (
    .clk(clk), .mul_lo(cmd.mul_lo), .mul_hi(cmd.mul_hi), .mul_fin(cmd.mul_fin),
    .a(a_op), .b(b_op), .s(cmd.s), .mres(mres)
  );

  assign dist_len = len_t'({16'd0, rdist});
  assign db = len_t'({22'd0, acc_deadband});
  assign vlim = len_t'({22'd0, vel_clamp});
  assign take_range = present && ({32'd0, rdist} < ({48'd0, range_max} << FRAC_BITS));
  assign ref_take = take_range ? sat48(ext50(baro) - ext50(dist_len)) : baro;
  assign as_new = sat48(ext50(accel_smooth) + ext50(mres));
  assign v_new = sat48(ext50(vel_state) + ext50(mres));

  always_comb begin
    case (cmd.a)
      A_RNG_DIFF: a_op = sat48(ext50(dist_len) - ext50(range_smooth));
      A_RNG:      a_op = range_smooth;
      A_REL:      a_op = rel;
      A_FUS_DIFF: a_op = sat48(ext50(fused) - ext50(fused_lowpass));
      A_ACC_DIFF: a_op = sat48(ext50(dead) - ext50(accel_smooth));
      A_HERR:     a_op = height_error;
      A_T1:       a_op = t1;
      A_VEL:      a_op = vel_state;
      A_ACCZ:     a_op = accz;
      A_T3:       a_op = t3;
      default:    a_op = t1;
    endcase
    case (cmd.b)
      B_LPF:   b_op = GAIN_LPF;
      B_QUAL:  b_op = {8'd0, qual};
      B_QINV:  b_op = {8'd0, ONE_Q16 - qual};
      B_FB:    b_op = GAIN_FEEDBACK;
      B_W:     b_op = {8'd0, w};
      B_DT:    b_op = {1'b0, dt};
      default: b_op = GAIN_LPF;
    endcase
    pos_take = take_range ? dist_len : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baro_weight <= 17'd22938;
      acc_deadband <= 26'd262144;
      vel_clamp <= 26'd8519680;
      quality_threshold <= 17'd19661;
      range_max <= 16'd400;
      range_smooth <= '0;
      accel_smooth <= '0;
      fused_lowpass <= '0;
      takeoff_ref <= '0;
      pos_state <= '0;
      vel_state <= '0;
      height_error <= '0;
      height_reset_pending <= 1'b0;
      full_reset_pending <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BARO_WEIGHT:       baro_weight <= cfg_data[16:0];
          CFG_ACC_DEADBAND:      acc_deadband <= cfg_data;
          CFG_VEL_CLAMP:         vel_clamp <= cfg_data;
          CFG_QUALITY_THRESHOLD: quality_threshold <= cfg_data[16:0];
          CFG_RANGE_MAX:         range_max <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        if (height_reset_req) height_reset_pending <= 1'b1;
        if (full_reset_req) full_reset_pending <= 1'b1;
      end
      if (cmd.alu_en) begin
        case (cmd.op)
          OP_RNG: begin
            if (present) range_smooth <= sat48(ext50(range_smooth) + ext50(mres));
          end
          OP_QUAL: begin
            if (present && (qual >= quality_threshold)) begin
              takeoff_ref <= sat48(ext50(baro) - ext50(range_smooth));
            end
          end
          OP_FLP: fused_lowpass <= sat48(ext50(fused_lowpass) + ext50(mres));
          OP_RESET: begin
            // A pending height reset is served first; a full reset then waits a tick.
            if (height_reset_pending) begin
              height_reset_pending <= 1'b0;
              takeoff_ref <= ref_take;
              pos_state <= take_range ? dist_len : fused;
            end else if (full_reset_pending) begin
              full_reset_pending <= 1'b0;
              accel_smooth <= '0;
              fused_lowpass <= '0;
              takeoff_ref <= ref_take;
              vel_state <= '0;
              pos_state <= pos_take;
            end
          end
          OP_ASM: accel_smooth <= as_new;
          OP_POSV: begin
            pos_state <= sat48(ext50(pos_state) + ext50(t2) + ext50(mres));
            vel_state <= sat48(ext50(vel_state) + ext50(t3));
          end
          OP_HERR: height_error <= sat48(ext50(fused) - ext50(pos_state));
          OP_EW: pos_state <= sat48(ext50(pos_state) + ext50(mres));
          OP_VFIN: begin
            if (hold && (v_new > vlim)) vel_state <= vlim;
            else if (hold && (v_new < -vlim)) vel_state <= -vlim;
            else vel_state <= v_new;
          end
          default: ;
        endcase
      end
    end
  end

  // Item fields and temporaries need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      baro <= baro_alt;
      rdist <= range_dist;
      qual <= range_quality;
      present <= range_present;
      acc <= accel_z;
      dt <= step_time;
      hold <= hold_or_land;
    end
    if (cmd.alu_en) begin
      case (cmd.op)
        OP_PREP: begin
          rel <= sat48(ext50(baro) - ext50(takeoff_ref));
          if (qual > ONE_Q16) qual <= ONE_Q16;
          w <= (baro_weight > ONE_Q16) ? ONE_Q16 : baro_weight;
          if ((acc < db) && (acc > -db)) dead <= '0;
          else if (acc > 0) dead <= acc - db;
          else dead <= acc + db;
        end
        OP_QUAL: begin
          if (present) begin
            if (qual < quality_threshold) qual <= '0;
            else w <= qual;
          end
        end
        OP_T1: t1 <= mres;
        OP_FUSE: fused <= present ? sat48(ext50(t1) + ext50(mres)) : rel;
        OP_RESET: begin
          if (height_reset_pending) begin
            w <= GAIN_RESET;
            if (take_range) fused <= dist_len;
          end else if (full_reset_pending) begin
            fused <= pos_take;
          end
        end
        OP_ASM: begin
          if (!hold) accout <= dead;
          else if (as_new > ACC_LIM) accout <= ACC_LIM;
          else if (as_new < -ACC_LIM) accout <= -ACC_LIM;
          else accout <= as_new;
        end
        OP_ACCZ: accz <= sat48(ext50(dead) - ext50(mres));
        OP_T2: t2 <= mres;
        OP_T3: t3 <= mres;
        OP_EW: t1 <= mres;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      accel_out <= accout;
      position_est <= pos_state;
      velocity_est <= vel_state;
      fused_smooth <= fused_lowpass;
    end
  end

endmodule

// ===== design/height_complementary_estimator.sv =====
// Top level of the complementary-filter height estimator.
// Joins hce_ctrl, hce_datapath (with hce_mulq) and uses hce_pkg.
//
//   Channel  Handshake            Carries
//   in       in_valid/in_ready    one estimator tick: sensor readings, dt, flags
//   out      out_valid/out_ready  accel_out, position_est, velocity_est, fused_smooth
//   cfg      cfg_we               cfg_index selects a register, cfg_data its value
//
// Each item is worked on to its end before the next one is taken: 15 products go
// through the one shared multiplier, each as two partial products, round and
// saturate, then the update; there are also four update steps without a product,
// and the hand-off to the output register.
// Reset is synchronous; it loads the register defaults and leaves a full estimator
// reset pending for the first item. A stalled output holds its result, and the next
// item is accepted and worked on meanwhile; it only waits at its own hand-off.
module height_complementary_estimator import hce_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  len_t        baro_alt,
  input  logic [31:0] range_dist,
  input  logic [16:0] range_quality,
  input  logic        range_present,
  input  len_t        accel_z,
  input  logic [23:0] step_time,
  input  logic        hold_or_land,
  input  logic        height_reset_req,
  input  logic        full_reset_req,
  output logic        out_valid,
  input  logic        out_ready,
  output len_t        accel_out,
  output len_t        position_est,
  output len_t        velocity_est,
  output len_t        fused_smooth,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  cmd_t cmd;

  // The controller owns sequencing and both handshakes.
  hce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  // The datapath holds every value and does the arithmetic the commands call for.
  hce_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .baro_alt(baro_alt), .range_dist(range_dist), .range_quality(range_quality),
    .range_present(range_present), .accel_z(accel_z), .step_time(step_time),
    .hold_or_land(hold_or_land), .height_reset_req(height_reset_req),
    .full_reset_req(full_reset_req),
    .accel_out(accel_out), .position_est(position_est),
    .velocity_est(velocity_est), .fused_smooth(fused_smooth)
  );

  // Once an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in work");

  // A new result only appears at the end of an item's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

endmodule

// ===== dv/hce_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the height estimator: mirrors the fixed-point filter tick by tick.
// Watches the in, out and cfg channels of height_complementary_estimator; uses hce_pkg.
module hce_checker import hce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  len_t        baro_alt,
  input  logic [31:0] range_dist,
  input  logic [16:0] range_quality,
  input  logic        range_present,
  input  len_t        accel_z,
  input  logic [23:0] step_time,
  input  logic        hold_or_land,
  input  logic        height_reset_req,
  input  logic        full_reset_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  len_t        accel_out,
  input  len_t        position_est,
  input  len_t        velocity_est,
  input  len_t        fused_smooth,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  output int          outstanding,
  output int          checked,
  output int          errors
);

  localparam longint SAT_HI = (longint'(1) <<< 47) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 47);

  typedef struct {
    len_t acc;
    len_t pos;
    len_t vel;
    len_t fus;
  } estimate_t;

  estimate_t estimates_due[$];

  longint unsigned w_baro, deadband, vel_lim, q_thresh, rmax;
  longint rng_lp, acc_lp, fus_lp, ref_h, pos, vel, herr;
  bit h_pend, f_pend;

  function automatic longint clip48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Rounded (half away from zero) and saturated a*b >> s.
  function automatic longint scale(longint a, longint unsigned b, int unsigned s);
    longint lim;
    longint unsigned m, ph, pl, t, r, res;
    bit neg;
    lim = longint'(1) <<< 50;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    neg = a < 0;
    m = neg ? longint'(-a) : a;
    b = b & 64'h1FF_FFFF;
    ph = (m >> 24) * b;
    pl = (m & 64'hFF_FFFF) * b + (64'd1 << (s - 1));
    t = ph + (pl >> 24);
    r = pl & 64'hFF_FFFF;
    if (s >= 24) res = t >> (s - 24);
    else res = (t << (24 - s)) + (r >> s);
    if (res > (64'd1 << 48)) res = 64'd1 << 48;
    return clip48(neg ? -longint'(res) : longint'(res));
  endfunction

  function automatic longint smooth(longint x, longint y);
    return clip48(x + scale(clip48(y - x), 6554, 16));
  endfunction

  function automatic longint clampsym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic estimate_t run_tick();
    estimate_t e;
    longint baro, rdist, acc, rel, fused, dead, db, accz, aout, ewdt;
    longint unsigned qual, dt, w;
    bit present, hold, take_range;
    baro = longint'(baro_alt);
    rdist = longint'({32'd0, range_dist});
    qual = range_quality;
    present = range_present;
    acc = longint'(accel_z);
    dt = step_time;
    hold = hold_or_land;
    w = (w_baro > 65536) ? 65536 : w_baro;
    take_range = present && (rdist < longint'(rmax << 16));
    if (height_reset_req) h_pend = 1;
    if (full_reset_req) f_pend = 1;
    if (qual > 65536) qual = 65536;

    rel = clip48(baro - ref_h);
    if (present) begin
      rng_lp = smooth(rng_lp, rdist);
      if (qual < q_thresh) begin
        qual = 0;
      end else begin
        w = qual;
        ref_h = clip48(baro - rng_lp);
      end
      fused = clip48(scale(rng_lp, qual, 16) + scale(rel, 65536 - qual, 16));
    end else begin
      fused = rel;
    end
    fus_lp = smooth(fus_lp, fused);

    // A height reset wins; a full reset waits for the following tick.
    if (h_pend) begin
      h_pend = 0;
      w = 62259;
      ref_h = baro;
      if (take_range) begin
        ref_h = clip48(baro - rdist);
        fused = rdist;
      end
      pos = fused;
    end else if (f_pend) begin
      f_pend = 0;
      acc_lp = 0;
      fused = 0;
      fus_lp = 0;
      ref_h = baro;
      if (take_range) begin
        ref_h = clip48(baro - rdist);
        fused = rdist;
      end
      vel = 0;
      pos = fused;
    end

    db = longint'(deadband);
    if (acc < db && acc > -db) dead = 0;
    else if (acc > 0) dead = acc - db;
    else dead = acc + db;
    acc_lp = smooth(acc_lp, dead);
    aout = hold ? clampsym(acc_lp, longint'(1000) <<< 16) : dead;

    accz = scale(scale(scale(scale(herr, 1311, 16), w, 16), w, 16), dt, 24);
    accz = clip48(dead - accz);
    pos = clip48(pos + scale(vel, dt, 24) + scale(scale(accz, dt, 24), dt, 25));
    vel = clip48(vel + scale(accz, dt, 24));
    herr = clip48(fused - pos);
    ewdt = scale(scale(herr, w, 16), dt, 24);
    pos = clip48(pos + ewdt);
    vel = clip48(vel + scale(ewdt, w, 16));
    if (hold) vel = clampsym(vel, longint'(vel_lim));

    e.acc = aout[47:0];
    e.pos = pos[47:0];
    e.vel = vel[47:0];
    e.fus = fus_lp[47:0];
    return e;
  endfunction

  task automatic compare(string what, len_t want, len_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  assign outstanding = estimates_due.size();

  always @(posedge clk) begin
    estimate_t e;
    if (rst) begin
      w_baro = 22938;
      deadband = 262144;
      vel_lim = 8519680;
      q_thresh = 19661;
      rmax = 400;
      rng_lp = 0; acc_lp = 0; fus_lp = 0; ref_h = 0;
      pos = 0; vel = 0; herr = 0;
      h_pend = 0;
      f_pend = 1;
      checked = 0;
      errors = 0;
      estimates_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BARO_WEIGHT:       w_baro = cfg_data[16:0];
          CFG_ACC_DEADBAND:      deadband = cfg_data;
          CFG_VEL_CLAMP:         vel_lim = cfg_data;
          CFG_QUALITY_THRESHOLD: q_thresh = cfg_data[16:0];
          CFG_RANGE_MAX:         rmax = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (estimates_due.size() == 0) begin
          errors++;
          $display("%0t: result item with no tick outstanding", $time);
        end else begin
          e = estimates_due.pop_front();
          checked++;
          compare("accel_out", e.acc, accel_out);
          compare("position_est", e.pos, position_est);
          compare("velocity_est", e.vel, velocity_est);
          compare("fused_smooth", e.fus, fused_smooth);
        end
      end
      if (in_valid && in_ready) estimates_due.push_back(run_tick());
    end
  end

endmodule

// ===== dv/height_complementary_estimator_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the height estimator test.
// Drives height_complementary_estimator; hce_checker predicts and compares results.
module height_complementary_estimator_test;
  import hce_pkg::*;

  // A tick's work is far shorter than STALL_LIMIT, so that long with no item moving
  // on either channel means the block is stuck.
  localparam int STALL_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  len_t        baro_alt = '0;
  logic [31:0] range_dist = '0;
  logic [16:0] range_quality = '0;
  logic        range_present = 0;
  len_t        accel_z = '0;
  logic [23:0] step_time = '0;
  logic        hold_or_land = 0;
  logic        height_reset_req = 0;
  logic        full_reset_req = 0;
  logic        out_valid;
  logic        out_ready = 0;
  len_t        accel_out, position_est, velocity_est, fused_smooth;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;

  int outstanding, checked, errors;
  int sent = 0;
  int quiet_cycles = 0;
  bit calm = 0;

  always #1 clk = ~clk;

  height_complementary_estimator u_dut (.*);

  hce_checker u_chk (.*);

  // The receiver stalls in about 19 percent of cycles, except in calm stretches.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 19);
  end

  // Watchdog on the handshakes.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic len_t rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Offer one tick. The fields are set up by the caller before
  // valid rises; valid stays high with a steady payload until the block takes it.
  task automatic offer_tick();
    @(negedge clk);
    while (!calm && $urandom_range(99) < 19) @(negedge clk);
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 0;
    sent++;
  endtask

  task automatic drive_tick(len_t baro, logic [31:0] rdist, logic [16:0] qual, logic pres,
                            len_t acc, logic [23:0] dt, logic hold, logic hreq, logic freq);
    baro_alt <= baro;
    range_dist <= rdist;
    range_quality <= qual;
    range_present <= pres;
    accel_z <= acc;
    step_time <= dt;
    hold_or_land <= hold;
    height_reset_req <= hreq;
    full_reset_req <= freq;
    offer_tick();
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [25:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(logic [16:0] bw, logic [25:0] db, logic [25:0] vl,
                               logic [16:0] qt, logic [15:0] rm);
    drain();
    write_reg(CFG_BARO_WEIGHT, bw);
    write_reg(CFG_ACC_DEADBAND, db);
    write_reg(CFG_VEL_CLAMP, vl);
    write_reg(CFG_QUALITY_THRESHOLD, qt);
    write_reg(CFG_RANGE_MAX, rm);
    cfg_we <= 0;
  endtask

  // Mostly plausible flight ticks with random content; some full-width noise.
  task automatic random_tick();
    len_t baro, acc;
    logic [31:0] rdist;
    logic [23:0] dt;
    if ($urandom_range(9) == 0) begin
      drive_tick(rand48(), $urandom, 17'($urandom), 1'($urandom), rand48(), 24'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      baro = $signed({$urandom_range(65535), 16'(0)}) - (len_t'(32768) <<< 16) + $urandom;
      acc = len_t'($signed(32'($urandom))) >>> $urandom_range(12);
      rdist = $urandom_range(2) == 0 ? $urandom
                                     : ($urandom_range(600) << 16) | $urandom_range(65535);
      dt = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(200000));
      drive_tick(baro, rdist, 17'($urandom_range(70000)), $urandom_range(3) != 0, acc, dt,
                 1'($urandom), $urandom_range(15) == 0, $urandom_range(31) == 0);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed ticks at the defaults: extremes, resets, quality corner cases.
    drive_tick('0, 32'd0, 17'd0, 0, '0, 24'd0, 0, 0, 0);
    drive_tick(48'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 17'd65536, 1, 48'sh7FFF_FFFF_FFFF,
               24'hFF_FFFF, 1, 0, 0);
    drive_tick(48'sh8000_0000_0000, 32'd0, 17'h1FFFF, 1, 48'sh8000_0000_0000,
               24'hFF_FFFF, 0, 1, 1);
    drive_tick(48'sh0000_1234_0000, 32'd100 << 16, 17'd65536, 1, 48'sh0000_0010_0000,
               24'd40000, 1, 1, 1);
    drive_tick(48'sh0000_1235_0000, 32'd120 << 16, 17'd1000, 1, -48'sh0000_0003_0000,
               24'd40000, 1, 0, 0);
    drive_tick(48'sh0000_1236_0000, 32'd500 << 16, 17'd30000, 1, 48'sh0000_0003_FFFF,
               24'd40000, 0, 1, 0);
    drive_tick(48'sh0000_1236_0000, 32'd0, 17'd19661, 1, -48'sh0000_0004_0000,
               24'd40000, 1, 0, 1);
    drive_tick(48'sh0000_1237_0000, 32'd50 << 16, 17'd19660, 1, 48'sh0000_0004_0001,
               24'd40000, 1, 0, 0);
    drive_tick(48'sh0000_1238_0000, 32'd50 << 16, 17'd50000, 0, 48'sh7FFF_FFFF_FFFF,
               24'hFF_FFFF, 1, 0, 0);
    drive_tick(48'sh8000_0000_0000, 32'hFFFF_FFFF, 17'd65535, 1, 48'sh8000_0000_0000,
               24'hFF_FFFF, 1, 0, 0);
    drive_tick(48'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 17'd65535, 1, 48'sh7FFF_FFFF_FFFF,
               24'hFF_FFFF, 0, 0, 1);
    drive_tick(rand48(), 32'h5555_5555, 17'h0AAAA, 1, rand48(), 24'h55_5555, 1, 0, 0);
    drive_tick(rand48(), 32'hAAAA_AAAA, 17'h15555, 1, rand48(), 24'hAA_AAAA, 0, 0, 0);

    // Random phases across several register settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_settings(17'd22938, 26'd262144, 26'd8519680, 17'd19661, 16'd400);
        1: load_settings(17'h1FFFF, 26'h3FF_FFFF, 26'h3FF_FFFF, 17'h1FFFF, 16'hFFFF);
        2: load_settings(17'd0, 26'd0, 26'd0, 17'd0, 16'd0);
        3: load_settings(17'd65536, 26'd65535999, 26'd65536, 17'd65536, 16'd65535);
        default: load_settings(17'($urandom), 26'($urandom), 26'($urandom),
                               17'($urandom_range(65536)), 16'($urandom_range(700)));
      endcase
      for (int k = 0; k < 88; k++) begin
        calm = (phase == 2 && k < 60);
        // Once, hold the sender off until every result is back.
        if (phase == 3 && k == 40) drain();
        random_tick();
      end
      calm = 0;
    end

    drain();
    repeat (100) @(negedge clk);
    $display("Ran %0d ticks across five register settings, resets and full-range noise;",
             sent);
    $display("%0d results compared, %0d mismatches.", checked, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hce_pkg.sv
design/hce_mulq.sv
design/hce_ctrl.sv
design/hce_datapath.sv
design/height_complementary_estimator.sv
dv/hce_checker.sv
dv/height_complementary_estimator_test.sv
